/* design/wsfe_pkg.sv */
// Shared types and constants for the WebSocket client frame encoder.
// No dependencies; used by every module of the encoder.
package wsfe_pkg;

	// Input opcodes
	localparam logic OP_BEGIN   = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	// Command kinds passed from the front end to the back end
	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_DATA  = 2'd1;
	localparam logic [1:0] CMD_ERR   = 2'd2;

	// Header byte sequence of a begin command
	localparam logic [2:0] STEP_HDR    = 3'd0;
	localparam logic [2:0] STEP_LEN    = 3'd1;
	localparam logic [2:0] STEP_LEN_HI = 3'd2;
	localparam logic [2:0] STEP_LEN_LO = 3'd3;
	localparam logic [2:0] STEP_KEY0   = 3'd4;
	localparam logic [2:0] STEP_KEY3   = 3'd7;

	localparam logic [7:0]  FIN_BIT     = 8'h80;
	localparam logic [7:0]  MASK_BIT    = 8'h80;
	localparam logic [6:0]  LEN16_CODE  = 7'd126;
	localparam logic [15:0] SHORT_MAX   = 16'd125;
	localparam logic [15:0] MAX_LEN_RST = 16'hFFFF;

	localparam int CMD_DEPTH = 4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  frame_kind;
		logic [15:0] length;
		logic [31:0] key;
		logic [7:0]  data;
		logic        last;
	} cmd_t;

endpackage

/* design/wsfe_front.sv */
// Front end: accepts input items, tracks the open frame and masks payload bytes.
// Depends on wsfe_pkg; feeds wsfe_cmd_fifo.
module wsfe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [15:0]         cfg_wdata,
	input  logic                accept,
	input  logic                opcode,
	input  logic [3:0]          frame_kind,
	input  logic [15:0]         payload_length,
	input  logic [31:0]         mask_key,
	input  logic [7:0]          data_byte,
	output logic                cmd_wr,
	output wsfe_pkg::cmd_t      cmd
);

	logic [15:0] max_len_q;
	logic        in_frame_q;
	logic [15:0] bytes_left_q;
	logic [1:0]  phase_q;
	logic [31:0] mask_word_q;

	logic        too_long;
	logic [15:0] left_next;
	logic        fin;
	logic [1:0]  sel;
	logic [7:0]  mask_byte;

	assign too_long  = payload_length > max_len_q;
	assign left_next = bytes_left_q - 16'd1;
	assign fin       = left_next == 16'd0;
	assign sel       = 2'd3 - phase_q;
	assign mask_byte = mask_word_q[{sel, 3'b000} +: 8];

	always_comb begin
		cmd.kind       = wsfe_pkg::CMD_DATA;
		cmd.frame_kind = frame_kind;
		cmd.length     = payload_length;
		cmd.key        = mask_key;
		cmd.data       = data_byte ^ mask_byte;
		cmd.last       = fin;
		cmd_wr         = 1'b0;
		if (accept) begin
			if (opcode == wsfe_pkg::OP_BEGIN) begin
				cmd_wr   = 1'b1;
				cmd.kind = too_long ? wsfe_pkg::CMD_ERR : wsfe_pkg::CMD_BEGIN;
			end else begin
				cmd_wr = in_frame_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q    <= wsfe_pkg::MAX_LEN_RST;
			in_frame_q   <= 1'b0;
			bytes_left_q <= 16'd0;
			phase_q      <= 2'd0;
			mask_word_q  <= 32'd0;
		end else begin
			if (cfg_wen) begin
				max_len_q <= cfg_wdata;
			end
			if (accept) begin
				if (opcode == wsfe_pkg::OP_BEGIN) begin
					phase_q <= 2'd0;
					if (too_long) begin
						in_frame_q   <= 1'b0;
						bytes_left_q <= 16'd0;
					end else begin
						in_frame_q   <= payload_length != 16'd0;
						bytes_left_q <= payload_length;
						mask_word_q  <= mask_key;
					end
				end else if (in_frame_q) begin
					// advance to the next payload byte
					bytes_left_q <= left_next;
					phase_q      <= phase_q + 2'd1;
					if (fin) begin
						in_frame_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

/* design/wsfe_cmd_fifo.sv */
// Short command queue between the front end and the back end.
// Depends on wsfe_pkg for the command type.
module wsfe_cmd_fifo #(
	parameter int DEPTH = wsfe_pkg::CMD_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  wsfe_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           rd_en,
	output wsfe_pkg::cmd_t rd_cmd,
	output logic           empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	wsfe_pkg::cmd_t mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full   = count_q == CNT_W'(DEPTH);
	assign empty  = count_q == '0;
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* design/wsfe_back.sv */
// Back end: expands queued commands into frame bytes and holds the output register.
// Depends on wsfe_pkg; reads from wsfe_cmd_fifo.
module wsfe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  wsfe_pkg::cmd_t head,
	input  logic           head_empty,
	output logic           head_pop,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     out_byte,
	output logic           is_header,
	output logic           last,
	output logic           error
);

	logic [2:0] step_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       hdr_q;
	logic       last_q;
	logic       err_q;

	logic       out_ready;
	logic       emit;
	logic       short_len;
	logic [1:0] key_sel;
	logic [7:0] nx_byte;
	logic       nx_hdr;
	logic       nx_last;
	logic       nx_err;
	logic       final_step;
	logic [2:0] nx_step;

	assign out_ready = !out_valid_q || pop;
	assign emit      = !head_empty && out_ready;
	assign short_len = head.length <= wsfe_pkg::SHORT_MAX;
	assign key_sel   = 2'd3 - step_q[1:0];
	assign head_pop  = emit && final_step;

	always_comb begin
		nx_byte    = 8'd0;
		nx_hdr     = 1'b0;
		nx_last    = 1'b0;
		nx_err     = 1'b0;
		final_step = 1'b1;
		nx_step    = step_q + 3'd1;
		case (head.kind)
			wsfe_pkg::CMD_BEGIN: begin
				nx_hdr     = 1'b1;
				final_step = step_q == wsfe_pkg::STEP_KEY3;
				case (step_q)
					wsfe_pkg::STEP_HDR: begin
						nx_byte = wsfe_pkg::FIN_BIT | {4'd0, head.frame_kind};
					end
					wsfe_pkg::STEP_LEN: begin
						if (short_len) begin
							nx_byte = wsfe_pkg::MASK_BIT | {1'b0, head.length[6:0]};
							nx_step = wsfe_pkg::STEP_KEY0;
						end else begin
							nx_byte = wsfe_pkg::MASK_BIT | {1'b0, wsfe_pkg::LEN16_CODE};
						end
					end
					wsfe_pkg::STEP_LEN_HI: begin
						nx_byte = head.length[15:8];
					end
					wsfe_pkg::STEP_LEN_LO: begin
						nx_byte = head.length[7:0];
					end
					default: begin
						nx_byte = head.key[{key_sel, 3'b000} +: 8];
						nx_last = (step_q == wsfe_pkg::STEP_KEY3) && (head.length == 16'd0);
					end
				endcase
			end
			wsfe_pkg::CMD_DATA: begin
				nx_byte = head.data;
				nx_last = head.last;
			end
			default: begin
				nx_err = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= nx_byte;
			hdr_q  <= nx_hdr;
			last_q <= nx_last;
			err_q  <= nx_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= wsfe_pkg::STEP_HDR;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				step_q <= final_step ? wsfe_pkg::STEP_HDR : nx_step;
			end
		end
	end

	assign empty     = !out_valid_q;
	assign out_byte  = byte_q;
	assign is_header = hdr_q;
	assign last      = last_q;
	assign error     = err_q;

endmodule

/* design/websocket_client_frame_encoder_unit.sv */
// Top level of the masked client WebSocket frame encoder.
// Depends on wsfe_pkg, wsfe_front, wsfe_cmd_fifo and wsfe_back.
//
//   channel   handshake        payload
//   -------   --------------   ----------------------------------------------------
//   input     push / full      opcode, frame_kind, payload_length, mask_key, data_byte
//   result    pop / empty      out_byte, is_header, last, error
//   config    cfg_wen          cfg_wdata (max_length)
//
// The front end takes one item per cycle while the command queue (CMD_DEPTH entries)
// has room. The back end writes one byte per cycle into the output register while it is
// empty or popped: a payload byte or an error gives one byte, a begin six (length up to
// 125) or eight. An item passes the queue and the output register before its first byte.
// Reset clears frame state, queue and output register; max_length returns to 65535.
// A result held (pop low) stalls the back end, the front end only once the queue fills.
module websocket_client_frame_encoder_unit #(
	parameter int CMD_DEPTH = wsfe_pkg::CMD_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	// input items
	input  logic        push,
	output logic        full,
	input  logic        opcode,
	input  logic [3:0]  frame_kind,
	input  logic [15:0] payload_length,
	input  logic [31:0] mask_key,
	input  logic [7:0]  data_byte,
	// result bytes
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        is_header,
	output logic        last,
	output logic        error
);

	logic           accept;
	logic           cmd_wr;
	wsfe_pkg::cmd_t cmd;
	wsfe_pkg::cmd_t head;
	logic           head_empty;
	logic           head_pop;

	// transfer on the input side
	assign accept = push && !full;

	// classify items, track the frame and mask payload bytes
	wsfe_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.accept         (accept),
		.opcode         (opcode),
		.frame_kind     (frame_kind),
		.payload_length (payload_length),
		.mask_key       (mask_key),
		.data_byte      (data_byte),
		.cmd_wr         (cmd_wr),
		.cmd            (cmd)
	);

	// decouple item acceptance from byte emission
	wsfe_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_wr),
		.wr_cmd (cmd),
		.full   (full),
		.rd_en  (head_pop),
		.rd_cmd (head),
		.empty  (head_empty)
	);

	// expand commands into wire bytes
	wsfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.is_header  (is_header),
		.last       (last),
		.error      (error)
	);

	// an error result carries no frame byte
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && error |-> out_byte == 8'd0 && !is_header && !last)
	else $error("error result with frame byte content");

	// the front end never writes a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_wr |-> !full)
	else $error("command written into full queue");

	// a waiting result is neither dropped nor changed
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_byte) && $stable(last))
	else $error("held result lost or changed");

	// a header byte never carries the error flag
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && is_header |-> !error)
	else $error("header byte flagged as error");

endmodule
